@@ sv/card_queue_cut_and_riffle_macros.svh @@
// ============================================================================
// card_queue_cut_and_riffle_macros.svh
// Assertion macros for the card queue; empty bodies in synthesis.
// ============================================================================
`ifndef CARD_QUEUE_CUT_AND_RIFFLE_MACROS_SVH
`define CARD_QUEUE_CUT_AND_RIFFLE_MACROS_SVH

`ifndef SYNTHESIS

`define CQCR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cqcr assertion failed");

`define CQCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cqcr assertion failed");

`else

`define CQCR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define CQCR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/cqcr_pkg.sv @@
// ============================================================================
// cqcr_pkg
// Types and constants shared by the card queue modules.
// ============================================================================
package cqcr_pkg;

    localparam int DECK_DEPTH  = 64;
    localparam int ADDR_W      = 6;
    localparam int CNT_W       = 7;
    localparam int FRESH_SUITS = 4;
    localparam int FRESH_RANKS = 13;
    localparam int FRESH_COUNT = FRESH_SUITS * FRESH_RANKS;

    localparam logic [7:0] SUIT_CHARS [FRESH_SUITS] = '{8'h43, 8'h44, 8'h48, 8'h53};
    localparam logic [7:0] RANK_CHARS [FRESH_RANKS] = '{
        8'h41, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h54, 8'h4A, 8'h51, 8'h4B
    };

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_PUT    = 2'd1,
        CMD_GET    = 2'd2,
        CMD_RIFFLE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GET,
        S_FILL,
        S_RIFFLE,
        S_DRAIN,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] card_value;
        logic [6:0]  cut_count;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] out_card;
        logic        card_valid;
        logic [1:0]  status_code;
        logic [6:0]  deck_count;
    } t_out_beat;

endpackage

@@ sv/card_queue_cut_and_riffle.sv @@
// ============================================================================
// card_queue_cut_and_riffle
// Bounded card FIFO with fresh load, put, get and cut-and-riffle commands.
// ============================================================================
//  channel | direction | beat       | handshake
//  in      | input     | t_in_beat  | i_in_valid / o_in_ready
//  out     | output    | t_out_beat | o_out_valid / i_out_ready
//
//  Accept to result: put, get on an empty deck and a cut that leaves the deck
//  as it is go straight to the result state; get runs S_GET, fresh load S_FILL,
//  any other cut S_RIFFLE and S_DRAIN; the riffle streams one card a cycle
//  through the store's single read port to the spare bank, which becomes the deck.
//  Reset clears the queue to empty; the stores need no clearing.
//  A result waiting on i_out_ready holds the block in its result state.
// ============================================================================
`include "card_queue_cut_and_riffle_macros.svh"

module card_queue_cut_and_riffle (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  cqcr_pkg::t_in_beat   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output cqcr_pkg::t_out_beat  o_out_data
);

    localparam int AW = cqcr_pkg::ADDR_W;
    localparam int CW = cqcr_pkg::CNT_W;

    cqcr_pkg::t_state  r_state, n_state;
    logic [AW-1:0]     r_top, n_top;
    logic [CW-1:0]     r_count, n_count;
    logic              r_bank, n_bank;
    logic [CW-1:0]     r_cut, n_cut;
    logic [CW-1:0]     r_a, n_a;
    logic [CW-1:0]     r_b, n_b;
    logic [CW-1:0]     r_k, n_k;
    logic              r_phase, n_phase;
    logic              r_wr_pend, n_wr_pend;
    logic [AW-1:0]     r_wr_addr, n_wr_addr;
    logic [1:0]        r_suit, n_suit;
    logic [3:0]        r_rank, n_rank;
    logic [15:0]       r_res_card, n_res_card;
    logic              r_res_valid, n_res_valid;
    cqcr_pkg::t_status r_res_status, n_res_status;
    logic              r_out_valid;
    cqcr_pkg::t_out_beat r_out_data;

    logic              in_accept;
    logic              load_out;
    logic [CW-1:0]     cut_sat;
    logic              a_left, b_left, take_b;
    logic [CW-1:0]     src_off;
    logic [AW-1:0]     rd_addr;
    logic              act_we;
    logic [AW-1:0]     act_wr_addr;
    logic [15:0]       act_wr_data;
    logic [15:0]       rd_data0, rd_data1, act_rd_data;
    logic              card_beat, status_ok, riffle_ok, get_hit;

    assign o_in_ready  = (r_state == cqcr_pkg::S_IDLE);
    assign in_accept   = i_in_valid && o_in_ready;
    assign cut_sat     = (i_in_data.cut_count > r_count) ? r_count : i_in_data.cut_count;
    assign act_rd_data = r_bank ? rd_data1 : rd_data0;

    assign a_left  = (r_a < r_cut);
    assign b_left  = (r_b < r_count);
    assign take_b  = (a_left && b_left) ? r_phase : !a_left;
    assign src_off = take_b ? r_b : r_a;

    cqcr_ram u_bank0 (
        .i_clk     (i_clk),
        .i_we      (r_bank ? r_wr_pend : act_we),
        .i_wr_addr (r_bank ? r_wr_addr : act_wr_addr),
        .i_wr_data (r_bank ? rd_data1 : act_wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data0)
    );

    cqcr_ram u_bank1 (
        .i_clk     (i_clk),
        .i_we      (r_bank ? act_we : r_wr_pend),
        .i_wr_addr (r_bank ? act_wr_addr : r_wr_addr),
        .i_wr_data (r_bank ? act_wr_data : rd_data0),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data1)
    );

    always_comb begin
        n_state      = r_state;
        n_top        = r_top;
        n_count      = r_count;
        n_bank       = r_bank;
        n_cut        = r_cut;
        n_a          = r_a;
        n_b          = r_b;
        n_k          = r_k;
        n_phase      = r_phase;
        n_wr_pend    = 1'b0;
        n_wr_addr    = r_wr_addr;
        n_suit       = r_suit;
        n_rank       = r_rank;
        n_res_card   = r_res_card;
        n_res_valid  = r_res_valid;
        n_res_status = r_res_status;
        rd_addr      = r_top;
        act_we       = 1'b0;
        act_wr_addr  = r_top + r_count[AW-1:0];
        act_wr_data  = i_in_data.card_value;
        load_out     = 1'b0;

        unique case (r_state)
            cqcr_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_res_card   = 16'h0000;
                    n_res_valid  = 1'b0;
                    n_res_status = cqcr_pkg::ST_OK;
                    n_state      = cqcr_pkg::S_RESULT;
                    unique case (i_in_data.command)
                        cqcr_pkg::CMD_LOAD: begin
                            n_k     = '0;
                            n_suit  = '0;
                            n_rank  = '0;
                            n_state = cqcr_pkg::S_FILL;
                        end
                        cqcr_pkg::CMD_PUT: begin
                            if (r_count == CW'(cqcr_pkg::DECK_DEPTH)) begin
                                n_res_status = cqcr_pkg::ST_FULL;
                            end else begin
                                act_we  = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        cqcr_pkg::CMD_GET: begin
                            if (r_count == '0) begin
                                n_res_status = cqcr_pkg::ST_EMPTY;
                            end else begin
                                n_state = cqcr_pkg::S_GET;
                            end
                        end
                        cqcr_pkg::CMD_RIFFLE: begin
                            if (cut_sat != '0 && cut_sat != r_count) begin
                                n_cut   = cut_sat;
                                n_a     = '0;
                                n_b     = cut_sat;
                                n_k     = '0;
                                n_phase = 1'b0;
                                n_state = cqcr_pkg::S_RIFFLE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            cqcr_pkg::S_GET: begin
                n_res_card  = act_rd_data;
                n_res_valid = 1'b1;
                n_top       = r_top + AW'(1);
                n_count     = r_count - CW'(1);
                n_state     = cqcr_pkg::S_RESULT;
            end
            cqcr_pkg::S_FILL: begin
                act_we      = 1'b1;
                act_wr_addr = r_k[AW-1:0];
                act_wr_data = {cqcr_pkg::RANK_CHARS[r_rank], cqcr_pkg::SUIT_CHARS[r_suit]};
                n_k         = r_k + CW'(1);
                if (r_rank == 4'(cqcr_pkg::FRESH_RANKS - 1)) begin
                    n_rank = '0;
                    n_suit = r_suit + 2'd1;
                end else begin
                    n_rank = r_rank + 4'd1;
                end
                if (r_k == CW'(cqcr_pkg::FRESH_COUNT - 1)) begin
                    n_count = CW'(cqcr_pkg::FRESH_COUNT);
                    n_top   = '0;
                    n_state = cqcr_pkg::S_RESULT;
                end
            end
            cqcr_pkg::S_RIFFLE: begin
                rd_addr   = r_top + src_off[AW-1:0];
                n_phase   = !r_phase;
                n_wr_pend = 1'b1;
                n_wr_addr = r_k[AW-1:0];
                n_k       = r_k + CW'(1);
                if (take_b) begin
                    n_b = r_b + CW'(1);
                end else begin
                    n_a = r_a + CW'(1);
                end
                if (r_k == r_count - CW'(1)) begin
                    n_state = cqcr_pkg::S_DRAIN;
                end
            end
            cqcr_pkg::S_DRAIN: begin
                n_bank  = !r_bank;
                n_top   = '0;
                n_state = cqcr_pkg::S_RESULT;
            end
            cqcr_pkg::S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = cqcr_pkg::S_IDLE;
                end
            end
            default: n_state = cqcr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cqcr_pkg::S_IDLE;
            r_top     <= '0;
            r_count   <= '0;
            r_bank    <= 1'b0;
            r_wr_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_top     <= n_top;
            r_count   <= n_count;
            r_bank    <= n_bank;
            r_wr_pend <= n_wr_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cut        <= n_cut;
        r_a          <= n_a;
        r_b          <= n_b;
        r_k          <= n_k;
        r_phase      <= n_phase;
        r_wr_addr    <= n_wr_addr;
        r_suit       <= n_suit;
        r_rank       <= n_rank;
        r_res_card   <= n_res_card;
        r_res_valid  <= n_res_valid;
        r_res_status <= n_res_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data.out_card    <= r_res_card;
            r_out_data.card_valid  <= r_res_valid;
            r_out_data.status_code <= r_res_status;
            r_out_data.deck_count  <= r_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign card_beat = o_out_valid && o_out_data.card_valid;
    assign status_ok = (o_out_data.status_code == cqcr_pkg::ST_OK);
    assign riffle_ok = (r_k < r_count) && (r_cut < r_count);
    assign get_hit   = in_accept && i_in_data.command == cqcr_pkg::CMD_GET && r_count != '0;

    `CQCR_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(cqcr_pkg::DECK_DEPTH))
    `CQCR_ASSERT_IMPLY(a_card_ok, i_clk, i_rst_n, card_beat, status_ok)
    `CQCR_ASSERT_IMPLY(a_idle_no_wr, i_clk, i_rst_n, r_state == cqcr_pkg::S_IDLE, !r_wr_pend)
    `CQCR_ASSERT_IMPLY(a_riffle_range, i_clk, i_rst_n, r_state == cqcr_pkg::S_RIFFLE, riffle_ok)
    `CQCR_ASSERT_NEXT(a_get_hold, i_clk, i_rst_n, get_hit, r_count == $past(r_count))
    `CQCR_ASSERT_NEXT(a_get_state, i_clk, i_rst_n, get_hit, r_state == cqcr_pkg::S_GET)

endmodule

@@ sv/cqcr_ram.sv @@
// ============================================================================
// cqcr_ram
// Card store: one write port, one read port with registered read data.
// ============================================================================
module cqcr_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [cqcr_pkg::ADDR_W-1:0] i_wr_addr,
    input  logic [15:0]                i_wr_data,
    input  logic [cqcr_pkg::ADDR_W-1:0] i_rd_addr,
    output logic [15:0]                o_rd_data
);

    logic [15:0] r_mem [cqcr_pkg::DECK_DEPTH];
    logic [15:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ bench/cqcr_deck_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// cqcr_deck_checker
// Watches both channels of the card queue. Each accepted command beat is
// played against a private copy of the deck to get the result it should
// give. Each result beat is compared field by field with the oldest result
// still owed. Mismatches are counted and handed to the bench top.
// ============================================================================
module cqcr_deck_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  cqcr_pkg::t_in_beat  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  cqcr_pkg::t_out_beat i_out_data,
    output int                  o_errors,
    output int                  o_pending
);

    localparam logic [8*4-1:0]  SUIT_STR = "CDHS";
    localparam logic [8*13-1:0] RANK_STR = "A23456789TJQK";

    logic [15:0]         deck [cqcr_pkg::DECK_DEPTH];
    int                  top_slot;
    int                  held;
    cqcr_pkg::t_out_beat results_owed [$];
    int                  mismatch_count;

    initial begin
        top_slot       = 0;
        held           = 0;
        mismatch_count = 0;
        o_pending      = 0;
    end

    assign o_errors = mismatch_count;

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    // Applies one command to the private deck and returns the result it owes.
    task automatic play_command(input cqcr_pkg::t_in_beat cmd,
                                output cqcr_pkg::t_out_beat res);
        logic [15:0] mix [cqcr_pkg::DECK_DEPTH];
        int          n;
        int          a;
        int          b;
        int          k;
        res = '0;
        case (cqcr_pkg::t_cmd'(cmd.command))
            cqcr_pkg::CMD_LOAD: begin
                k = 0;
                for (int s = 0; s < 4; s++) begin
                    for (int rk = 0; rk < 13; rk++) begin
                        if (k < cqcr_pkg::DECK_DEPTH) begin
                            deck[k] = {RANK_STR[8*(12-rk) +: 8], SUIT_STR[8*(3-s) +: 8]};
                            k++;
                        end
                    end
                end
                top_slot = 0;
                held     = k;
            end
            cqcr_pkg::CMD_PUT: begin
                if (held >= cqcr_pkg::DECK_DEPTH) begin
                    res.status_code = cqcr_pkg::ST_FULL;
                end else begin
                    deck[(top_slot + held) % cqcr_pkg::DECK_DEPTH] = cmd.card_value;
                    held++;
                end
            end
            cqcr_pkg::CMD_GET: begin
                if (held == 0) begin
                    res.status_code = cqcr_pkg::ST_EMPTY;
                end else begin
                    res.out_card   = deck[top_slot];
                    res.card_valid = 1'b1;
                    top_slot       = (top_slot + 1) % cqcr_pkg::DECK_DEPTH;
                    held--;
                end
            end
            default: begin
                n = int'(cmd.cut_count);
                if (n > held) n = held;
                if (n != 0 && n != held) begin
                    a = 0;
                    b = n;
                    k = 0;
                    while (a < n && b < held) begin
                        mix[k]     = deck[(top_slot + a) % cqcr_pkg::DECK_DEPTH];
                        mix[k + 1] = deck[(top_slot + b) % cqcr_pkg::DECK_DEPTH];
                        k += 2;
                        a++;
                        b++;
                    end
                    while (a < n) begin
                        mix[k] = deck[(top_slot + a) % cqcr_pkg::DECK_DEPTH];
                        k++;
                        a++;
                    end
                    while (b < held) begin
                        mix[k] = deck[(top_slot + b) % cqcr_pkg::DECK_DEPTH];
                        k++;
                        b++;
                    end
                    for (int i = 0; i < held; i++) deck[i] = mix[i];
                    top_slot = 0;
                end
            end
        endcase
        res.deck_count = 7'(held);
    endtask

    always @(posedge i_clk) begin
        cqcr_pkg::t_out_beat want;
        cqcr_pkg::t_out_beat owed;
        if (i_rst_n) begin
            // result side first, so a beat can never match its own command
            if (i_out_valid && i_out_ready) begin
                if (results_owed.size() == 0) begin
                    report_mismatch("result beat with nothing owed");
                end else begin
                    want = results_owed.pop_front();
                    check_field("out_card", i_out_data.out_card, want.out_card);
                    check_field("card_valid", i_out_data.card_valid, want.card_valid);
                    check_field("status_code", i_out_data.status_code, want.status_code);
                    check_field("deck_count", i_out_data.deck_count, want.deck_count);
                end
            end
            if (i_in_valid && i_in_ready) begin
                play_command(i_in_data, owed);
                results_owed.push_back(owed);
            end
            o_pending <= results_owed.size();
        end
    end

endmodule

@@ bench/tb_card_queue_cut_and_riffle.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_card_queue_cut_and_riffle
// Drives command beats into the card queue: a directed opening over empty,
// full, fresh-load and cut edge cases, then random runs that fill, drain or
// balance the deck. Both sides idle at random except for one calm
// stretch. The checker beside the block supplies the mismatch count.
// ============================================================================
module tb_card_queue_cut_and_riffle;

    localparam int RANDOM_BEATS = 1525;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 80;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    cqcr_pkg::t_in_beat  in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    cqcr_pkg::t_out_beat out_data;
    logic                calm      = 1'b0;
    int                  errors;
    int                  pending;
    int                  quiet_cycles = 0;

    always #5 clk = ~clk;

    card_queue_cut_and_riffle DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    cqcr_deck_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always @(posedge clk) begin
        out_ready <= calm || ($urandom_range(99) >= 29);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Valid is only dropped while idling, so back-to-back beats never see a
    // low and a high assigned in the same step.
    task automatic send_beat(input cqcr_pkg::t_cmd cmd, input logic [15:0] card,
                             input int cut);
        while (!calm && $urandom_range(99) < 29) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid           <= 1'b1;
        in_data.command    <= cmd;
        in_data.card_value <= card;
        in_data.cut_count  <= 7'(cut);
        do @(posedge clk); while (!in_ready);
    endtask

    initial begin
        int             mode;
        int             roll;
        cqcr_pkg::t_cmd cmd;
        logic [15:0]    card;
        int             cut;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_beat(cqcr_pkg::CMD_GET, 16'h0000, 0);
        send_beat(cqcr_pkg::CMD_RIFFLE, 16'h0000, 5);
        send_beat(cqcr_pkg::CMD_LOAD, 16'h0000, 0);
        for (int i = 0; i < 12; i++) begin
            card = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'($urandom());
            send_beat(cqcr_pkg::CMD_PUT, card, 0);
        end
        send_beat(cqcr_pkg::CMD_PUT, 16'hA55A, 0);
        send_beat(cqcr_pkg::CMD_RIFFLE, 16'h0000, 63);
        send_beat(cqcr_pkg::CMD_RIFFLE, 16'h0000, 64);
        send_beat(cqcr_pkg::CMD_RIFFLE, 16'h0000, 0);
        send_beat(cqcr_pkg::CMD_GET, 16'h0000, 0);
        send_beat(cqcr_pkg::CMD_LOAD, 16'h0000, 0);
        send_beat(cqcr_pkg::CMD_RIFFLE, 16'h0000, 26);
        send_beat(cqcr_pkg::CMD_RIFFLE, 16'h0000, 1);
        send_beat(cqcr_pkg::CMD_RIFFLE, 16'h0000, 51);
        send_beat(cqcr_pkg::CMD_RIFFLE, 16'h0000, 52);

        mode = 0;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 50 == 0) mode = $urandom_range(2);
            calm = (n >= 500 && n < 800);
            roll = $urandom_range(99);
            // mode 0 fills, mode 1 drains, mode 2 is balanced
            if (roll < 4) begin
                cmd = cqcr_pkg::CMD_LOAD;
            end else if (roll < 19) begin
                cmd = cqcr_pkg::CMD_RIFFLE;
            end else if (mode == 0) begin
                cmd = (roll < 80) ? cqcr_pkg::CMD_PUT : cqcr_pkg::CMD_GET;
            end else if (mode == 1) begin
                cmd = (roll < 35) ? cqcr_pkg::CMD_PUT : cqcr_pkg::CMD_GET;
            end else begin
                cmd = (roll < 60) ? cqcr_pkg::CMD_PUT : cqcr_pkg::CMD_GET;
            end
            card = ($urandom_range(3) == 0) ?
                   {8'($urandom_range(8'h20, 8'h7E)), 8'($urandom_range(8'h20, 8'h7E))} :
                   16'($urandom());
            roll = $urandom_range(9);
            cut  = (roll == 0) ? 0 : (roll == 1) ? 64 : $urandom_range(64);
            send_beat(cmd, card, cut);
        end
        calm     = 1'b0;
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/cqcr_pkg.sv
sv/cqcr_ram.sv
sv/card_queue_cut_and_riffle.sv
bench/cqcr_deck_checker.sv
bench/tb_card_queue_cut_and_riffle.sv
